// ===== rtl/core/steering_iir_pwm_controller_defines.svh =====
// assertion macros used by the steering controller checker
`ifndef STEERING_IIR_PWM_CONTROLLER_DEFINES_SVH
`define STEERING_IIR_PWM_CONTROLLER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define SIPC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define SIPC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/sipc_pkg.sv =====
// shared types, constants and codes of the steering controller
package sipc_pkg;

    // default values of the top-level parameters
    localparam int DEF_PWM_FULL_SCALE = 17000;
    localparam int DEF_COEF_WIDTH     = 24;

    // field widths
    localparam int SENSOR_W  = 12;
    localparam int REF_W     = 17;
    localparam int ACCEL_W   = 16;
    localparam int PWM_W     = 15;
    localparam int EFFORT_W  = 18;
    localparam int TICKS_W   = 16;
    localparam int ERR_W     = 21;
    localparam int CFG_IDX_W = 3;

    // datapath widths
    localparam int MUL_A_W  = 32;
    localparam int MUL_B_W  = 28;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;
    localparam int ACC_W    = 56;
    localparam int ANGLE_W  = 28;
    localparam int X_W      = 27;
    localparam int Q_W      = 20;
    localparam int RECIP_SH = 32;
    localparam int DUTY_W   = 17;
    localparam int FRAC_W   = 16;

    // register indexes; the coefficient indexes also select the filter tap
    localparam logic [CFG_IDX_W-1:0] REG_COEF_B0       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_B1       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_B2       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_A1       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_A2       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_TIMEOUT = 3'd5;
    localparam int NUM_TAPS = 5;

    // register reset values
    localparam int COEF_B0_RESET       = 393216;
    localparam int ACCEL_TIMEOUT_RESET = 500;

    // wheel map, Q16
    localparam logic [SENSOR_W-1:0] BREAK_POINT = 12'd1857;
    localparam int SLOPE_HI  = -10420;
    localparam int OFFSET_HI = 25244467;
    localparam int SLOPE_LO  = -11384;
    localparam int OFFSET_LO = 27039498;

    // error scaling: divide by 90 via reciprocal floor(2^32 / 90)
    localparam int ERR_DIV  = 90;
    localparam int ERR_HALF = 45;
    localparam int RECIP_90 = 47721858;

    // effort clamp and rounding
    localparam longint ACC_ONE  = 64'sd4294967296;
    localparam int     HALF_LSB = 32768;
    localparam int     ONE_Q16  = 65536;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WHEEL,
        ST_DIFF,
        ST_RECIP,
        ST_QUOT,
        ST_ERR,
        ST_TAP,
        ST_ACC,
        ST_CLAMP,
        ST_PWM,
        ST_OUT
    } sipc_state_t;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_WHEEL,
        MUL_RECIP,
        MUL_QUOT,
        MUL_TAP,
        MUL_PWM
    } sipc_mul_sel_t;

    typedef struct packed {
        sipc_mul_sel_t          mul_sel;
        logic [CFG_IDX_W-1:0]   tap_idx;
        logic                   load_sample;
        logic                   load_x;
        logic                   load_q0;
        logic                   load_err;
        logic                   acc_clr;
        logic                   acc_add;
        logic                   load_effort;
        logic                   load_out;
    } sipc_cmd_t;

    typedef struct packed {
        logic out_free;
    } sipc_status_t;

endpackage

// ===== rtl/core/sipc_sample_if.sv =====
// input channel: one control tick per beat
interface sipc_sample_if;
    import sipc_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [SENSOR_W-1:0]        wheel_sensor;
    logic signed [REF_W-1:0]    angle_ref;
    logic                       accel_received;
    logic signed [ACCEL_W-1:0]  accel_value;

    modport source (
        output valid, wheel_sensor, angle_ref, accel_received, accel_value,
        input  ready
    );

    modport sink (
        input  valid, wheel_sensor, angle_ref, accel_received, accel_value,
        output ready
    );
endinterface

// ===== rtl/core/sipc_result_if.sv =====
// output channel: one result per beat
interface sipc_result_if;
    import sipc_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [PWM_W-1:0]           pwm_right;
    logic [PWM_W-1:0]           pwm_left;
    logic signed [EFFORT_W-1:0] drive_effort;
    logic signed [ACCEL_W-1:0]  accel_out;

    modport source (
        output valid, pwm_right, pwm_left, drive_effort, accel_out,
        input  ready
    );

    modport sink (
        input  valid, pwm_right, pwm_left, drive_effort, accel_out,
        output ready
    );
endinterface

// ===== rtl/core/steering_iir_pwm_controller.sv =====
// top level of the steering controller: second-order iir with pwm drive
//
//  channel   | dir | payload                                             | beat
//  ----------+-----+-----------------------------------------------------+----------------
//  sample    | in  | wheel_sensor, angle_ref, accel_received, accel_value | one tick
//  result    | out | pwm_right, pwm_left, drive_effort, accel_out         | one per tick
//  cfg       | in  | cfg_we, cfg_index, cfg_wdata                         | one reg write
//
// a tick runs through the sequencer steps from one accepted beat to the next; the
// result goes valid when the output register loads; a single 32x28 multiplier
// serves the wheel map, divide by 90 (reciprocal multiply plus one
// correction), five filter taps and the pwm scaling
// the result sits in an output register, so a new sample is taken while the
// previous result waits; a stalled result only holds the sequencer in its
// last step until the output register frees up
// reset clears the sequencer, the filter history, the acceleration hold and
// loads the register reset values; there is no clearing pass
module steering_iir_pwm_controller #(
    parameter int PWM_FULL_SCALE = sipc_pkg::DEF_PWM_FULL_SCALE,
    parameter int COEF_WIDTH     = sipc_pkg::DEF_COEF_WIDTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [sipc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [COEF_WIDTH-1:0]          cfg_wdata,
    sipc_sample_if.sink                    sample,
    sipc_result_if.source                  result
);
    import sipc_pkg::*;

    // command and status between sequencer and datapath
    sipc_cmd_t    cmd;
    sipc_status_t status;
    logic         in_ready;

    // sequencer: one state per multiplier use outside the filter, one tap state with a counter for it
    sipc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sample.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    assign sample.ready = in_ready;

    // datapath: holds the registers, the history, the multiplier and the
    // output register that drives the result channel
    sipc_datapath #(
        .PWM_FULL_SCALE (PWM_FULL_SCALE),
        .COEF_WIDTH     (COEF_WIDTH)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .wheel_sensor   (sample.wheel_sensor),
        .angle_ref      (sample.angle_ref),
        .accel_received (sample.accel_received),
        .accel_value    (sample.accel_value),
        .cmd            (cmd),
        .status         (status),
        .out_ready      (result.ready),
        .out_valid      (result.valid),
        .pwm_right      (result.pwm_right),
        .pwm_left       (result.pwm_left),
        .drive_effort   (result.drive_effort),
        .accel_out      (result.accel_out)
    );
endmodule

// ===== rtl/core/sipc_ctrl.sv =====
// sequencer: walks one tick through the shared multiplier
module sipc_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  sipc_pkg::sipc_status_t status,
    output sipc_pkg::sipc_cmd_t    cmd
);
    import sipc_pkg::*;

    sipc_state_t          state_reg;
    sipc_state_t          state_next;
    logic [CFG_IDX_W-1:0] tap_reg;
    logic [CFG_IDX_W-1:0] tap_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            tap_reg   <= REG_COEF_B0;
        end
        else
        begin
            state_reg <= state_next;
            tap_reg   <= tap_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        tap_next    = tap_reg;
        in_ready    = 1'b0;
        cmd         = '0;
        cmd.mul_sel = MUL_NONE;
        cmd.tap_idx = tap_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_sample = 1'b1;
                    state_next      = ST_WHEEL;
                end
            end
            ST_WHEEL:
            begin
                cmd.mul_sel = MUL_WHEEL;
                state_next  = ST_DIFF;
            end
            ST_DIFF:
            begin
                cmd.load_x = 1'b1;
                state_next = ST_RECIP;
            end
            ST_RECIP:
            begin
                cmd.mul_sel = MUL_RECIP;
                state_next  = ST_QUOT;
            end
            ST_QUOT:
            begin
                cmd.mul_sel = MUL_QUOT;
                cmd.load_q0 = 1'b1;
                state_next  = ST_ERR;
            end
            ST_ERR:
            begin
                cmd.load_err = 1'b1;
                cmd.acc_clr  = 1'b1;
                tap_next     = REG_COEF_B0;
                state_next   = ST_TAP;
            end
            ST_TAP:
            begin
                // product of the previous tap lands in the accumulator
                cmd.mul_sel = MUL_TAP;
                cmd.acc_add = (tap_reg != REG_COEF_B0);
                if (tap_reg == REG_COEF_A2)
                begin
                    state_next = ST_ACC;
                end
                else
                begin
                    tap_next = tap_reg + 1'b1;
                end
            end
            ST_ACC:
            begin
                cmd.acc_add = 1'b1;
                state_next  = ST_CLAMP;
            end
            ST_CLAMP:
            begin
                cmd.load_effort = 1'b1;
                state_next      = ST_PWM;
            end
            ST_PWM:
            begin
                cmd.mul_sel = MUL_PWM;
                state_next  = ST_OUT;
            end
            ST_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end
endmodule

// ===== rtl/core/sipc_datapath.sv =====
// datapath: config registers, controller state, shared multiplier, output register
module sipc_datapath #(
    parameter int PWM_FULL_SCALE = sipc_pkg::DEF_PWM_FULL_SCALE,
    parameter int COEF_WIDTH     = sipc_pkg::DEF_COEF_WIDTH
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [sipc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [COEF_WIDTH-1:0]                 cfg_wdata,
    input  logic [sipc_pkg::SENSOR_W-1:0]         wheel_sensor,
    input  logic signed [sipc_pkg::REF_W-1:0]     angle_ref,
    input  logic                                  accel_received,
    input  logic signed [sipc_pkg::ACCEL_W-1:0]   accel_value,
    input  sipc_pkg::sipc_cmd_t                   cmd,
    output sipc_pkg::sipc_status_t                status,
    input  logic                                  out_ready,
    output logic                                  out_valid,
    output logic [sipc_pkg::PWM_W-1:0]            pwm_right,
    output logic [sipc_pkg::PWM_W-1:0]            pwm_left,
    output logic signed [sipc_pkg::EFFORT_W-1:0]  drive_effort,
    output logic signed [sipc_pkg::ACCEL_W-1:0]   accel_out
);
    import sipc_pkg::*;

    // coefficient store wide enough for the reset value of b0
    localparam int COEF_STORE_W = (COEF_WIDTH > 20) ? COEF_WIDTH : 20;

    // configuration
    logic signed [COEF_STORE_W-1:0] coef_reg [NUM_TAPS];
    logic [TICKS_W-1:0]             timeout_reg;

    // state carried from tick to tick
    logic signed [ERR_W-1:0]    err_hist1_reg;
    logic signed [ERR_W-1:0]    err_hist2_reg;
    logic signed [EFFORT_W-1:0] eff_hist1_reg;
    logic signed [EFFORT_W-1:0] eff_hist2_reg;
    logic [TICKS_W-1:0]         silence_reg;
    logic signed [ACCEL_W-1:0]  held_reg;

    // working registers of one tick
    logic [SENSOR_W-1:0]        sensor_reg;
    logic [REF_W-1:0]           ref_abs_reg;
    logic [X_W-1:0]             x_reg;
    logic                       neg_reg;
    logic [Q_W-1:0]             q0_reg;
    logic signed [ERR_W-1:0]    err_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]    acc_reg;

    // output register
    logic                       out_valid_reg;
    logic [PWM_W-1:0]           pwm_right_reg;
    logic [PWM_W-1:0]           pwm_left_reg;
    logic signed [EFFORT_W-1:0] effort_out_reg;
    logic signed [ACCEL_W-1:0]  accel_out_reg;

    logic [TICKS_W-1:0]         silence_inc;
    logic                       timed_out;
    logic [REF_W-1:0]           ref_abs;
    logic                       sensor_hi;
    logic signed [ANGLE_W-1:0]  wheel_q16;
    logic signed [ANGLE_W-1:0]  ref_q16;
    logic signed [ANGLE_W-1:0]  diff;
    logic [ANGLE_W-1:0]         diff_mag;
    logic [X_W-1:0]             x_next;
    logic [X_W-1:0]             rem;
    logic signed [ERR_W-1:0]    q_fix;
    logic signed [ERR_W-1:0]    err_next;
    logic signed [COEF_STORE_W-1:0] tap_coef;
    logic signed [MUL_B_W-1:0]  tap_op;
    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [PROD_W-1:0]   mul_prod;
    logic signed [ACC_W-1:0]    acc_rnd;
    logic signed [EFFORT_W-1:0] effort_next;
    logic [DUTY_W-1:0]          duty;
    logic                       effort_pos;
    logic [PWM_W-1:0]           pwm_val;

    // acceleration hold and timeout
    assign silence_inc = accel_received ? '0 : silence_reg + 1'b1;
    assign timed_out   = (silence_inc >= timeout_reg);
    assign ref_abs     = angle_ref[REF_W-1] ? REF_W'(-angle_ref) : REF_W'(angle_ref);

    // wheel angle and error magnitude
    assign sensor_hi = (sensor_reg >= BREAK_POINT);
    assign wheel_q16 = signed'(prod_reg[ANGLE_W-1:0])
                     + (sensor_hi ? ANGLE_W'(OFFSET_HI) : ANGLE_W'(OFFSET_LO));
    assign ref_q16   = signed'({3'b000, ref_abs_reg, 8'h00});
    assign diff      = ref_q16 - wheel_q16;
    assign diff_mag  = diff[ANGLE_W-1] ? ANGLE_W'(-diff) : ANGLE_W'(diff);
    assign x_next    = X_W'(diff_mag) + X_W'(ERR_HALF);

    // quotient correction: reciprocal estimate is exact or one low
    assign rem      = x_reg - prod_reg[X_W-1:0];
    assign q_fix    = signed'(ERR_W'(q0_reg) + ERR_W'(rem >= X_W'(ERR_DIV)));
    assign err_next = neg_reg ? -q_fix : q_fix;

    // filter tap operands
    always_comb
    begin
        unique case (cmd.tap_idx)
            REG_COEF_B0:
            begin
                tap_coef = coef_reg[0];
                tap_op   = MUL_B_W'(err_reg);
            end
            REG_COEF_B1:
            begin
                tap_coef = coef_reg[1];
                tap_op   = MUL_B_W'(err_hist1_reg);
            end
            REG_COEF_B2:
            begin
                tap_coef = coef_reg[2];
                tap_op   = MUL_B_W'(err_hist2_reg);
            end
            REG_COEF_A1:
            begin
                tap_coef = coef_reg[3];
                tap_op   = MUL_B_W'(eff_hist1_reg);
            end
            REG_COEF_A2:
            begin
                tap_coef = coef_reg[4];
                tap_op   = MUL_B_W'(eff_hist2_reg);
            end
            default:
            begin
                tap_coef = '0;
                tap_op   = '0;
            end
        endcase
    end

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.mul_sel)
            MUL_WHEEL:
            begin
                mul_a = sensor_hi ? MUL_A_W'(SLOPE_HI) : MUL_A_W'(SLOPE_LO);
                mul_b = signed'(MUL_B_W'(sensor_reg));
            end
            MUL_RECIP:
            begin
                mul_a = signed'(MUL_A_W'(x_reg));
                mul_b = MUL_B_W'(RECIP_90);
            end
            MUL_QUOT:
            begin
                mul_a = signed'(MUL_A_W'(prod_reg[RECIP_SH+Q_W-1:RECIP_SH]));
                mul_b = MUL_B_W'(ERR_DIV);
            end
            MUL_TAP:
            begin
                mul_a = MUL_A_W'(tap_coef);
                mul_b = tap_op;
            end
            MUL_PWM:
            begin
                mul_a = signed'(MUL_A_W'(duty));
                mul_b = MUL_B_W'(PWM_FULL_SCALE);
            end
            MUL_NONE:
            begin
                mul_a = '0;
                mul_b = '0;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_prod = mul_a * mul_b;

    // clamp to +/-1.0, otherwise round to Q16
    assign acc_rnd = acc_reg + ACC_W'(HALF_LSB);
    always_comb
    begin
        priority if (acc_reg > ACC_W'(ACC_ONE))
        begin
            effort_next = EFFORT_W'(ONE_Q16);
        end
        else if (acc_reg < -ACC_W'(ACC_ONE))
        begin
            effort_next = -EFFORT_W'(ONE_Q16);
        end
        else
        begin
            effort_next = acc_rnd[FRAC_W+EFFORT_W-1:FRAC_W];
        end
    end

    // pwm scaling
    assign duty       = eff_hist1_reg[EFFORT_W-1] ? DUTY_W'(-eff_hist1_reg)
                                                  : DUTY_W'(eff_hist1_reg);
    assign effort_pos = !eff_hist1_reg[EFFORT_W-1] && (eff_hist1_reg != '0);
    assign pwm_val    = prod_reg[FRAC_W+PWM_W-1:FRAC_W];

    // configuration and controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_TAPS; i++)
            begin
                coef_reg[i] <= (i == 0) ? COEF_STORE_W'(COEF_B0_RESET) : '0;
            end
            timeout_reg   <= TICKS_W'(ACCEL_TIMEOUT_RESET);
            err_hist1_reg <= '0;
            err_hist2_reg <= '0;
            eff_hist1_reg <= '0;
            eff_hist2_reg <= '0;
            silence_reg   <= '0;
            held_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                for (int i = 0; i < NUM_TAPS; i++)
                begin
                    if (cfg_index == CFG_IDX_W'(i))
                    begin
                        coef_reg[i] <= COEF_STORE_W'(signed'(cfg_wdata));
                    end
                end
                if (cfg_index == REG_ACCEL_TIMEOUT)
                begin
                    timeout_reg <= cfg_wdata[TICKS_W-1:0];
                end
            end
            if (cmd.load_sample)
            begin
                if (timed_out)
                begin
                    held_reg    <= '0;
                    silence_reg <= '0;
                end
                else
                begin
                    silence_reg <= silence_inc;
                    if (accel_received)
                    begin
                        held_reg <= accel_value;
                    end
                end
            end
            if (cmd.load_effort)
            begin
                err_hist2_reg <= err_hist1_reg;
                err_hist1_reg <= err_reg;
                eff_hist2_reg <= eff_hist1_reg;
                eff_hist1_reg <= effort_next;
            end
        end
    end

    // working registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd.load_sample)
        begin
            sensor_reg  <= wheel_sensor;
            ref_abs_reg <= ref_abs;
        end
        if (cmd.load_x)
        begin
            x_reg   <= x_next;
            neg_reg <= diff[ANGLE_W-1];
        end
        if (cmd.load_q0)
        begin
            q0_reg <= prod_reg[RECIP_SH+Q_W-1:RECIP_SH];
        end
        if (cmd.load_err)
        begin
            err_reg <= err_next;
        end
        if (cmd.mul_sel != MUL_NONE)
        begin
            prod_reg <= mul_prod;
        end
        if (cmd.acc_clr)
        begin
            acc_reg <= '0;
        end
        else if (cmd.acc_add)
        begin
            acc_reg <= acc_reg + signed'(prod_reg[ACC_W-1:0]);
        end
        if (cmd.load_out)
        begin
            pwm_right_reg  <= effort_pos ? pwm_val : '0;
            pwm_left_reg   <= effort_pos ? '0 : pwm_val;
            effort_out_reg <= eff_hist1_reg;
            accel_out_reg  <= held_reg;
        end
    end

    // output beat valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign pwm_right       = pwm_right_reg;
    assign pwm_left        = pwm_left_reg;
    assign drive_effort    = effort_out_reg;
    assign accel_out       = accel_out_reg;
endmodule

// ===== rtl/core/sipc_checker.sv =====
// port-level checks of the steering controller, bound to the top level
`include "steering_iir_pwm_controller_defines.svh"

module sipc_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic                                 in_ready,
    input  logic                                 out_valid,
    input  logic                                 out_ready,
    input  logic [sipc_pkg::PWM_W-1:0]           pwm_right,
    input  logic [sipc_pkg::PWM_W-1:0]           pwm_left,
    input  logic signed [sipc_pkg::EFFORT_W-1:0] drive_effort
);
    import sipc_pkg::*;

    localparam logic signed [EFFORT_W-1:0] EFF_MAX = EFFORT_W'(ONE_Q16);

    `SIPC_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready right after a beat")
    `SIPC_ASSERT_NOW(a_one_side, out_valid, pwm_right == '0 || pwm_left == '0, "both pwm sides on")
    `SIPC_ASSERT_NOW(a_right_sign, out_valid && pwm_right != '0, !drive_effort[EFFORT_W-1] && drive_effort != '0, "right pwm without positive effort")
    `SIPC_ASSERT_NOW(a_effort_range, out_valid, drive_effort <= EFF_MAX && drive_effort >= -EFF_MAX, "effort outside +/-1.0")
    `SIPC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(drive_effort), "stalled result changed")
endmodule

bind steering_iir_pwm_controller sipc_checker u_sipc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (sample.valid),
    .in_ready     (sample.ready),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .pwm_right    (result.pwm_right),
    .pwm_left     (result.pwm_left),
    .drive_effort (result.drive_effort)
);

// ===== tb/sv/tb_sipc_check_pkg.sv =====
// tick predictor and result scoreboard for the steering controller testbench
package tb_sipc_check_pkg;
    timeunit 1ns;
    timeprecision 1ps;
    import sipc_pkg::*;

    localparam int     COEF_W    = DEF_COEF_WIDTH;
    localparam longint PWM_SCALE = DEF_PWM_FULL_SCALE;
    localparam int     REF_LIMIT = 46080;

    // two-segment wheel map, Q16 degrees
    localparam int     MAP_BREAK     = 1857;
    localparam longint MAP_SLOPE_HI  = -10420;
    localparam longint MAP_OFFSET_HI = 25244467;
    localparam longint MAP_SLOPE_LO  = -11384;
    localparam longint MAP_OFFSET_LO = 27039498;

    localparam longint ERR_SCALE = 90;
    localparam longint UNITY     = 65536;
    localparam longint ACC_UNITY = 64'sd4294967296;
    localparam longint HALF_Q16  = 32768;

    // indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [SENSOR_W-1:0]       wheel_sensor;
        logic signed [REF_W-1:0]   angle_ref;
        logic                      accel_received;
        logic signed [ACCEL_W-1:0] accel_value;
    } tick_t;

    typedef struct packed {
        logic [PWM_W-1:0]           pwm_right;
        logic [PWM_W-1:0]           pwm_left;
        logic signed [EFFORT_W-1:0] drive_effort;
        logic signed [ACCEL_W-1:0]  accel_out;
    } drive_t;

    function automatic longint wheel_q16(input logic [SENSOR_W-1:0] sensor);
        longint s;
        s = sensor;
        if (sensor >= MAP_BREAK)
            return MAP_SLOPE_HI * s + MAP_OFFSET_HI;
        return MAP_SLOPE_LO * s + MAP_OFFSET_LO;
    endfunction

    class steering_tick_checker;
        logic signed [COEF_W-1:0]   tap_weight [NUM_TAPS];
        logic [TICKS_W-1:0]         timeout_ticks;
        logic signed [ERR_W-1:0]    err_d1;
        logic signed [ERR_W-1:0]    err_d2;
        logic signed [EFFORT_W-1:0] effort_d1;
        logic signed [EFFORT_W-1:0] effort_d2;
        logic [TICKS_W-1:0]         quiet_ticks;
        logic signed [ACCEL_W-1:0]  accel_hold;
        drive_t                     pending_drive [$];
        int                         mismatch_count;

        function new();
            restart();
            mismatch_count = 0;
        endfunction

        function void restart();
            foreach (tap_weight[k])
                tap_weight[k] = '0;
            tap_weight[REG_COEF_B0] = COEF_B0_RESET;
            timeout_ticks = ACCEL_TIMEOUT_RESET;
            err_d1 = '0;
            err_d2 = '0;
            effort_d1 = '0;
            effort_d2 = '0;
            quiet_ticks = '0;
            accel_hold = '0;
            pending_drive.delete();
        endfunction

        function void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] data);
            case (idx)
                REG_COEF_B0, REG_COEF_B1, REG_COEF_B2, REG_COEF_A1, REG_COEF_A2:
                    tap_weight[idx] = data;
                REG_ACCEL_TIMEOUT:
                    timeout_ticks = data[TICKS_W-1:0];
                default: ;
            endcase
        endfunction

        // one control tick: acceleration hold, wheel map, error, filter, pwm split
        function void take_tick(input tick_t t);
            longint angle, diff, mag, err, acc, effort, duty, pwm;
            drive_t d;
            if (t.accel_received) begin
                quiet_ticks = '0;
                accel_hold = t.accel_value;
            end
            else
                quiet_ticks = quiet_ticks + 1'b1;
            if (quiet_ticks >= timeout_ticks) begin
                accel_hold = '0;
                quiet_ticks = '0;
            end

            angle = t.angle_ref;
            if (angle < 0)
                angle = -angle;
            diff = angle * 256 - wheel_q16(t.wheel_sensor);
            mag = (diff < 0) ? -diff : diff;
            mag = (mag + ERR_SCALE / 2) / ERR_SCALE;
            err = (diff < 0) ? -mag : mag;

            acc = longint'(tap_weight[REG_COEF_B0]) * err
                + longint'(tap_weight[REG_COEF_B1]) * longint'(err_d1)
                + longint'(tap_weight[REG_COEF_B2]) * longint'(err_d2)
                + longint'(tap_weight[REG_COEF_A1]) * longint'(effort_d1)
                + longint'(tap_weight[REG_COEF_A2]) * longint'(effort_d2);
            if (acc > ACC_UNITY)
                effort = UNITY;
            else if (acc < -ACC_UNITY)
                effort = -UNITY;
            else
                effort = (acc + HALF_Q16) >>> 16;

            err_d2 = err_d1;
            err_d1 = err[ERR_W-1:0];
            effort_d2 = effort_d1;
            effort_d1 = effort[EFFORT_W-1:0];

            duty = (effort < 0) ? -effort : effort;
            pwm = (duty * PWM_SCALE) >> 16;
            d.pwm_right = (effort > 0) ? pwm[PWM_W-1:0] : '0;
            d.pwm_left = (effort > 0) ? '0 : pwm[PWM_W-1:0];
            d.drive_effort = effort[EFFORT_W-1:0];
            d.accel_out = accel_hold;
            pending_drive.push_back(d);
        endfunction

        function void compare_field(input string field, input longint want, input longint got);
            if (want != got) begin
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
                mismatch_count++;
            end
        endfunction

        function void check_drive(input drive_t got);
            drive_t want;
            if (pending_drive.size() == 0) begin
                $display("%0t: result beat with none expected, expected nothing, got effort %0d",
                         $time, got.drive_effort);
                mismatch_count++;
                return;
            end
            want = pending_drive.pop_front();
            compare_field("pwm_right", want.pwm_right, got.pwm_right);
            compare_field("pwm_left", want.pwm_left, got.pwm_left);
            compare_field("drive_effort", want.drive_effort, got.drive_effort);
            compare_field("accel_out", want.accel_out, got.accel_out);
        endfunction
    endclass

endpackage

// ===== tb/sv/tb_steering_iir_pwm_controller.sv =====
// top of the steering controller testbench: stimulus, register phases and result monitor
module tb_steering_iir_pwm_controller;
    timeunit 1ns;
    timeprecision 1ps;
    import sipc_pkg::*;
    import tb_sipc_check_pkg::*;

    localparam int PHASES          = 9;
    localparam int TICKS_PER_PHASE = 150;
    localparam int IDLE_PCT        = 19;
    localparam int QUIET_STRETCH   = 4;    // phase with no random idling on either side

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [COEF_W-1:0]    cfg_wdata = '0;

    // set while neither side may idle at random
    bit                   steady = 1'b0;
    drive_t               seen;
    steering_tick_checker tick_check;

    sipc_sample_if sample_ch ();
    sipc_result_if result_ch ();

    steering_iir_pwm_controller i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .sample    (sample_ch),
        .result    (result_ch)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // result side: random stalls, changed on the falling edge
    always @(negedge clk)
    begin
        result_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    // every accepted result beat is checked against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            seen.pwm_right    = result_ch.pwm_right;
            seen.pwm_left     = result_ch.pwm_left;
            seen.drive_effort = result_ch.drive_effort;
            seen.accel_out    = result_ch.accel_out;
            tick_check.check_drive(seen);
        end
    end

    // hold one sample beat until it is taken; entered and left on a falling edge
    task automatic send_tick(input tick_t t);
        sample_ch.valid          <= 1'b1;
        sample_ch.wheel_sensor   <= t.wheel_sensor;
        sample_ch.angle_ref      <= t.angle_ref;
        sample_ch.accel_received <= t.accel_received;
        sample_ch.accel_value    <= t.accel_value;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        tick_check.take_tick(t);
        @(negedge clk);
    endtask

    // stop sending until every predicted result has come back
    task automatic drain();
        sample_ch.valid <= 1'b0;
        while (tick_check.pending_drive.size() != 0)
            @(negedge clk);
    endtask

    // gap after a beat: a full drain halfway through a phase, else random idling
    task automatic pace(input int n);
        if (n == TICKS_PER_PHASE / 2)
            drain();
        else if (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            sample_ch.valid <= 1'b0;
            // long enough to land anywhere in a tick
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
    endtask

    // one register write per cycle; the caller drops the enable after the last
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        tick_check.write_reg(idx, data);
        @(negedge clk);
    endtask

    // register set for one phase; only called with the block idle
    task automatic program_phase(input int kind);
        logic [COEF_W-1:0] w [NUM_TAPS];
        logic [COEF_W-1:0] wait_word;
        int half;
        wait_word = $urandom;
        case (kind)
            0:
            begin
                // largest positive weights, longest timeout
                foreach (w[k])
                    w[k] = {1'b0, {(COEF_W-1){1'b1}}};
                wait_word[TICKS_W-1:0] = '1;
            end
            1:
            begin
                // most negative weights, timeout zero clears the hold every tick
                foreach (w[k])
                    w[k] = {1'b1, {(COEF_W-1){1'b0}}};
                wait_word[TICKS_W-1:0] = '0;
            end
            2:
            begin
                // all weights zero: effort always zero, left path
                foreach (w[k])
                    w[k] = '0;
                wait_word[TICKS_W-1:0] = 1;
            end
            3:
            begin
                // a plausible controller: stable feedback, short timeout
                w[REG_COEF_B0] = $urandom_range(524288, 65536);
                w[REG_COEF_B1] = -int'($urandom_range(262144));
                w[REG_COEF_B2] = $urandom_range(65536);
                w[REG_COEF_A1] = $urandom_range(49152);
                w[REG_COEF_A2] = -int'($urandom_range(16384));
                wait_word[TICKS_W-1:0] = $urandom_range(30, 2);
            end
            default:
            begin
                // random weights at a random scale, timeout short or anywhere
                half = 1 << $urandom_range(COEF_W - 1, 8);
                foreach (w[k])
                    w[k] = int'($urandom_range(2 * half)) - half;
                if ($urandom_range(1))
                    wait_word[TICKS_W-1:0] = $urandom_range(40, 1);
            end
        endcase
        write_reg(REG_SPARE_LO, $urandom);
        write_reg(REG_COEF_B0, w[REG_COEF_B0]);
        write_reg(REG_COEF_B1, w[REG_COEF_B1]);
        write_reg(REG_COEF_B2, w[REG_COEF_B2]);
        write_reg(REG_COEF_A1, w[REG_COEF_A1]);
        write_reg(REG_COEF_A2, w[REG_COEF_A2]);
        write_reg(REG_ACCEL_TIMEOUT, wait_word);
        write_reg(REG_SPARE_HI, $urandom);
        cfg_we <= 1'b0;
    endtask

    // random tick: mostly aimed near the wheel angle so the effort stays unclamped
    function automatic tick_t make_tick(input int accel_pct);
        tick_t t;
        longint aim;
        int pick, jitter, span;
        pick = $urandom_range(99);
        case ($urandom_range(9))
            0: t.wheel_sensor = '0;
            1: t.wheel_sensor = '1;
            2: t.wheel_sensor = MAP_BREAK - 1 + $urandom_range(2);
            default: t.wheel_sensor = $urandom;
        endcase
        if (pick < 55)
        begin
            jitter = $urandom_range(6000);
            aim = wheel_q16(t.wheel_sensor) / 256 + jitter - 3000;
            if (aim < 0)
                aim = -aim;
            if (aim > REF_LIMIT)
                aim = REF_LIMIT;
            // sign of the reference is dropped by the block
            if ($urandom_range(1))
                aim = -aim;
            t.angle_ref = aim[REF_W-1:0];
        end
        else if (pick < 90)
        begin
            span = $urandom_range(2 * REF_LIMIT);
            t.angle_ref = span - REF_LIMIT;
        end
        else
            t.angle_ref = $urandom;    // any 17-bit pattern
        t.accel_received = ($urandom_range(99) < accel_pct);
        t.accel_value = $urandom;
        return t;
    endfunction

    // directed ticks at the reset register values
    task automatic run_directed();
        tick_t plan [$];
        logic [SENSOR_W-1:0] null_sensor;
        longint wheel, null_angle, slack;
        // find a reading whose wheel angle sits within one error step of a reference
        null_sensor = MAP_BREAK - 1;
        forever
        begin
            wheel = wheel_q16(null_sensor);
            null_angle = (wheel + 128) / 256;
            slack = null_angle * 256 - wheel;
            if (slack < 0)
                slack = -slack;
            if (null_angle <= REF_LIMIT && slack <= ERR_SCALE / 2)
                break;
            null_sensor = null_sensor - 1'b1;
        end
        // sensor and reference extremes, both clamp directions
        plan.push_back('{12'd0, 17'sd0, 1'b1, 16'sh7fff});
        plan.push_back('{12'd4095, 17'sd46080, 1'b1, 16'sh8000});
        plan.push_back('{12'd0, -17'sd46080, 1'b0, 16'sh0000});
        plan.push_back('{12'd4095, 17'sh10000, 1'b0, 16'sh1234});
        plan.push_back('{12'd0, 17'sh0ffff, 1'b1, 16'sh5555});
        // both sides of the map break
        plan.push_back('{12'd1856, -17'sd46080, 1'b0, 16'sh0000});
        plan.push_back('{12'd1857, 17'sd23040, 1'b0, 16'sh0000});
        plan.push_back('{12'd1858, -17'sd23040, 1'b1, 16'sh0000});
        plan.push_back('{12'd1856, 17'sd0, 1'b0, 16'sh0000});
        plan.push_back('{12'd1857, 17'sd0, 1'b1, 16'shffff});
        // alternating bit patterns
        plan.push_back('{12'haaa, 17'h0aaaa, 1'b1, 16'haaaa});
        plan.push_back('{12'h555, 17'h15555, 1'b0, 16'h5555});
        // zero effort, then one reference step either way: right then left channel
        plan.push_back('{null_sensor, null_angle[REF_W-1:0], 1'b0, 16'sh0000});
        plan.push_back('{null_sensor, -null_angle[REF_W-1:0], 1'b1, 16'shffff});
        plan.push_back('{null_sensor, null_angle[REF_W-1:0] + 17'sd1, 1'b0, 16'sh0000});
        plan.push_back('{null_sensor, null_angle[REF_W-1:0] - 17'sd1, 1'b0, 16'sh0000});
        plan.push_back('{null_sensor, -(null_angle[REF_W-1:0] + 17'sd3), 1'b1, 16'sh0100});
        foreach (plan[i])
        begin
            send_tick(plan[i]);
            pace(i);
        end
    endtask

    initial
    begin
        int accel_pct;
        sample_ch.valid          = 1'b0;
        sample_ch.wheel_sensor   = '0;
        sample_ch.angle_ref      = '0;
        sample_ch.accel_received = 1'b0;
        sample_ch.accel_value    = '0;
        result_ch.ready          = 1'b0;
        tick_check = new();

        // single reset at the start
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        run_directed();

        for (int phase = 0; phase < PHASES; phase++)
        begin
            // registers change only with nothing in flight
            drain();
            program_phase(phase);
            case (phase % 3)
                0: accel_pct = 4;     // rare updates so the timeout fires
                1: accel_pct = 35;
                default: accel_pct = 90;
            endcase
            steady = (phase == QUIET_STRETCH);
            for (int n = 0; n < TICKS_PER_PHASE; n++)
            begin
                send_tick(make_tick(accel_pct));
                pace(n);
            end
            steady = 1'b0;
        end

        // wait out every prediction, then a margin for stray beats
        drain();
        repeat (40) @(negedge clk);
        if (tick_check.pending_drive.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, tick_check.pending_drive.size());
            tick_check.mismatch_count++;
        end
        if (tick_check.mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #3_000_000;
        $display("%0t: timed out with %0d results outstanding", $time,
                 tick_check.pending_drive.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
